### rtl/assert_macros.svh
// Assertion macros used by the hash unit accumulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion that is switched off while reset is active.
`define RPAH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Clocked assertion that is checked during reset too.
`define RPAH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

### rtl/rpah_pkg.sv
// Types, format codes and conversion functions of the row polynomial hash unit.
`timescale 1ns / 1ps
package rpah_pkg;
  localparam logic [3:0] FMT_DOUBLE = 4'd1;
  localparam logic [3:0] FMT_FLOAT  = 4'd2;
  localparam logic [3:0] FMT_S16    = 4'd3;
  localparam logic [3:0] FMT_S64A   = 4'd4;
  localparam logic [3:0] FMT_S64B   = 4'd5;
  localparam logic [3:0] FMT_S32    = 4'd6;
  localparam logic [3:0] FMT_S8     = 4'd7;
  localparam logic [3:0] FMT_U8     = 4'd8;
  localparam logic [3:0] FMT_U16    = 4'd9;
  localparam logic [3:0] FMT_U64A   = 4'd10;
  localparam logic [3:0] FMT_U64B   = 4'd11;
  localparam logic [3:0] FMT_U32    = 4'd12;

  localparam logic [1:0] REG_FORMAT  = 2'd0;
  localparam logic [1:0] REG_ROW_LEN = 2'd1;
  localparam logic [1:0] REG_SCALE   = 2'd2;

  typedef struct packed {
    logic [63:0] bits;
    logic        last;
  } elem_t;

  typedef struct packed {
    logic [31:0] value;
    logic        is_float;
    logic        last;
  } conv_t;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } term_t;

  // Truncates a float toward zero to a saturated 32-bit signed integer.
  function automatic logic [31:0] float_to_int(input logic sgn, input logic signed [12:0] uexp,
                                               input logic [52:0] mant, input logic is_nan);
    logic [30:0] mag;
    logic [5:0]  sh;
    sh  = 6'd52 - uexp[5:0];
    mag = 31'(mant >> sh);
    if (is_nan) return 32'h0;
    else if (uexp >= 13'sd31) return sgn ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else if (uexp < 13'sd0) return 32'h0;
    else return sgn ? (32'h0 - {1'b0, mag}) : {1'b0, mag};
  endfunction

  function automatic logic format_known(input logic [3:0] fmt);
    return (fmt >= FMT_DOUBLE) && (fmt <= FMT_U32);
  endfunction
endpackage

### rtl/rpah_convert.sv
// Element conversion stage: raw bits to a 32-bit integer per the element format.
`timescale 1ns / 1ps
module rpah_convert import rpah_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [3:0] fmt_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  elem_t      in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output conv_t      out_o
);
  logic        valid_q;
  conv_t       data_q, data_d;
  logic signed [12:0] ue_dbl, ue_sgl;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    ue_dbl = $signed({2'b0, in_i.bits[62:52]}) - 13'sd1023;
    ue_sgl = $signed({5'b0, in_i.bits[30:23]}) - 13'sd127;
    data_d = '0;
    data_d.last = in_i.last;
    unique case (fmt_i)
      FMT_DOUBLE: begin
        data_d.is_float = 1'b1;
        data_d.value = float_to_int(in_i.bits[63], ue_dbl, {1'b1, in_i.bits[51:0]},
                                    (in_i.bits[62:52] == 11'h7FF) && (in_i.bits[51:0] != '0));
      end
      FMT_FLOAT: begin
        data_d.is_float = 1'b1;
        data_d.value = float_to_int(in_i.bits[31], ue_sgl, {1'b1, in_i.bits[22:0], 29'b0},
                                    (in_i.bits[30:23] == 8'hFF) && (in_i.bits[22:0] != '0));
      end
      FMT_S16: data_d.value = {{16{in_i.bits[15]}}, in_i.bits[15:0]};
      FMT_S8:  data_d.value = {{24{in_i.bits[7]}}, in_i.bits[7:0]};
      FMT_U8:  data_d.value = {24'b0, in_i.bits[7:0]};
      FMT_U16: data_d.value = {16'b0, in_i.bits[15:0]};
      FMT_S64A, FMT_S64B, FMT_S32, FMT_U64A, FMT_U64B, FMT_U32:
        data_d.value = in_i.bits[31:0];
      default: data_d.value = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;
endmodule

### rtl/rpah_scale.sv
// Scaling stage: multiplies converted floating elements by the scale register.
`timescale 1ns / 1ps
module rpah_scale import rpah_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [19:0] scale_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  conv_t       in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output term_t       out_o
);
  logic  valid_q;
  term_t data_q, data_d;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    data_d.last  = in_i.last;
    data_d.value = in_i.is_float ? 32'(in_i.value * {12'b0, scale_i}) : in_i.value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;
endmodule

### rtl/rpah_accum.sv
// Row hash recurrence, row closing, running total and the result register.
`timescale 1ns / 1ps
module rpah_accum import rpah_pkg::*; #(
  parameter int unsigned MAX_ROW_LENGTH = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [3:0]  fmt_i,
  input  logic [15:0] row_len_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  term_t       in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_o
);
  `include "assert_macros.svh"

  logic [31:0] row_hash_q, row_hash_d, total_q, total_d, row_sum, len32, pos32;
  logic [15:0] pos_q, pos_d, pos_inc;
  logic        ov_q, go, close;
  logic [31:0] res_q;

  assign in_ready_o = !in_i.last || !ov_q || out_ready_i;
  assign go         = in_valid_i && in_ready_o;

  always_comb begin
    len32 = (row_len_i == 16'd0) ? 32'd1 : {16'b0, row_len_i};
    if (len32 > 32'(MAX_ROW_LENGTH)) len32 = 32'(MAX_ROW_LENGTH);
    row_sum = (row_hash_q << 5) - row_hash_q + in_i.value;
    pos_inc = pos_q + 16'd1;
    pos32   = {16'b0, pos_inc};
    close   = (pos32 >= len32) || (pos_inc == 16'd0) || in_i.last;
    total_d = (close && format_known(fmt_i)) ? total_q + row_sum : total_q;
    row_hash_d = close ? 32'd1 : row_sum;
    pos_d      = close ? 16'd0 : pos_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_hash_q <= 32'd1;
      total_q    <= 32'd0;
      pos_q      <= 16'd0;
      ov_q       <= 1'b0;
    end else begin
      if (go) begin
        row_hash_q <= row_hash_d;
        pos_q      <= pos_d;
        total_q    <= in_i.last ? 32'd0 : total_d;
      end
      if (go && in_i.last) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && in_i.last) res_q <= total_d;
  end

  assign out_valid_o = ov_q;
  assign out_o       = res_q;

  `RPAH_ASSERT(a_row_start_hash, (pos_q == 16'd0) |-> (row_hash_q == 32'd1), "row start hash not 1")
  `RPAH_ASSERT(a_last_loads_result, (go && in_i.last) |=> ov_q, "result not loaded")
  `RPAH_ASSERT(a_no_overwrite, (ov_q && !out_ready_i && in_valid_i && in_i.last) |-> !go,
               "pending result overwritten")
endmodule

### rtl/row_polynomial_array_hash_unit.sv
// Top level of the row polynomial array hash unit.
`timescale 1ns / 1ps
// Streams array elements in, one per accepted request, and returns one 32-bit
// hash per array on the element flagged with tlast. Elements are split into
// rows of row_length elements (0 acts as 1, capped at MAX_ROW_LENGTH); each row
// hash starts at 1 and becomes 31 times itself plus the element, and finished
// rows are summed modulo 2^32. A partial row is closed by the last element.
// Rows closed under an unknown element format add nothing. The unit takes one
// element per clock in steady state. Each element passes an input conversion
// register, a scaling register (one 32x20 multiply for float formats) and the
// accumulator, whose result register takes the array total with its last
// element. The result register lets new elements keep flowing while a result
// waits; only a following last element stalls until that result is taken.
// Configuration writes are always accepted and must be made while idle.
module row_polynomial_array_hash_unit import rpah_pkg::*; #(
  parameter int unsigned MAX_ROW_LENGTH = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // element_bits[63:0]
  input  logic        s_axis_tlast_i,   // last_element
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // hash_value[31:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);
  logic [3:0]  fmt_q;
  logic [15:0] row_len_q;
  logic [19:0] scale_q;

  elem_t in_elem;
  conv_t conv;
  term_t term;
  logic  conv_valid, conv_ready, term_valid, term_ready;

  // Configuration registers; every request is taken at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= FMT_S32;
      row_len_q <= 16'd1;
      scale_q   <= 20'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FORMAT:  fmt_q     <= cfg_data_i[3:0];
        REG_ROW_LEN: row_len_q <= cfg_data_i[15:0];
        REG_SCALE:   scale_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_elem.bits = s_axis_tdata_i;
  assign in_elem.last = s_axis_tlast_i;

  rpah_convert u_convert (
    .clk_i, .rst_ni, .fmt_i(fmt_q),
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o), .in_i(in_elem),
    .out_valid_o(conv_valid), .out_ready_i(conv_ready), .out_o(conv)
  );

  rpah_scale u_scale (
    .clk_i, .rst_ni, .scale_i(scale_q),
    .in_valid_i(conv_valid), .in_ready_o(conv_ready), .in_i(conv),
    .out_valid_o(term_valid), .out_ready_i(term_ready), .out_o(term)
  );

  rpah_accum #(.MAX_ROW_LENGTH(MAX_ROW_LENGTH)) u_accum (
    .clk_i, .rst_ni, .fmt_i(fmt_q), .row_len_i(row_len_q),
    .in_valid_i(term_valid), .in_ready_o(term_ready), .in_i(term),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i), .out_o(m_axis_tdata_o)
  );
endmodule
